FILE: rtl/tms_pkg.sv
// Package: shared types and constants for the tone melody sequencer.
`timescale 1ns / 1ps
package tms_pkg;

   localparam int MAX_NOTES  = 16;
   localparam int NOTE_IDX_W = $clog2(MAX_NOTES);
   localparam int NOTE_CNT_W = $clog2(MAX_NOTES + 1);

   localparam logic [NOTE_CNT_W-1:0] MAX_NOTES_CNT = NOTE_CNT_W'(MAX_NOTES);
   localparam logic [15:0]           GAP_MS_RESET  = 16'd18;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_LOAD = 2'd1,
      KIND_MUTE = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] note_freq;
      logic [15:0] note_dur;
      logic        first_note;
      logic        last_note;
      logic        gap_after;
      logic        mute_value;
   } req_type;

   typedef struct packed {
      logic [15:0] tone_freq;
      logic        tone_on;
      logic        is_playing;
      logic        is_muted;
   } rsp_type;

endpackage

FILE: rtl/tone_melody_sequencer.sv
// Top level: buzzer melody sequencer with note store, tick timing and mute.
// Each response is registered; a stalled output sends it to the skid entry.
// Throughput: one request per cycle unless stalled; one register pass each.
// A two-entry response buffer; req_stall rises only when both entries are full.
// Reset (synchronous, active high) empties the melody, stops play, unmutes and
// sets gap_ms to 18; note store contents are left as they are.
`timescale 1ns / 1ps
module tone_melody_sequencer (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  tms_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output tms_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [15:0]     csr_data
);
   import tms_pkg::*;

   logic [15:0]           freq_store_ff [MAX_NOTES];
   logic [15:0]           dur_store_ff  [MAX_NOTES];
   logic [NOTE_CNT_W-1:0] length_ff, length_in;
   logic [NOTE_CNT_W-1:0] position_ff, position_in;
   logic [15:0]           remaining_ff, remaining_in;
   logic                  playing_ff, playing_in;
   logic                  muted_ff, muted_in;
   logic [15:0]           cur_freq_ff, cur_freq_in;
   logic [15:0]           gap_ms_ff;

   logic                  rsp_valid_ff, skid_valid_ff;
   rsp_type               rsp_data_ff, skid_data_ff, result;

   logic                  accept, out_take;
   logic                  wr_note, wr_gap;
   logic [NOTE_IDX_W-1:0] note_idx, gap_idx, read_idx;
   logic [NOTE_CNT_W-1:0] len_a, len_b, pos_next;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      length_in    = length_ff;
      position_in  = position_ff;
      remaining_in = remaining_ff;
      playing_in   = playing_ff;
      muted_in     = muted_ff;
      cur_freq_in  = cur_freq_ff;
      wr_note      = 1'b0;
      wr_gap       = 1'b0;
      len_a        = req_data.first_note ? '0 : length_ff;
      len_b        = len_a + NOTE_CNT_W'(len_a < MAX_NOTES_CNT);
      note_idx     = len_a[NOTE_IDX_W-1:0];
      gap_idx      = len_b[NOTE_IDX_W-1:0];
      pos_next     = position_ff + NOTE_CNT_W'(1);
      read_idx     = pos_next[NOTE_IDX_W-1:0];
      case (req_data.kind)
         KIND_TICK: begin
            if (playing_ff) begin
               if (remaining_ff <= 16'd1) begin
                  position_in = pos_next;
                  if (pos_next >= length_ff) begin
                     playing_in  = 1'b0;
                     cur_freq_in = '0;
                  end else begin
                     cur_freq_in  = freq_store_ff[read_idx];
                     remaining_in = dur_store_ff[read_idx];
                  end
               end else begin
                  remaining_in = remaining_ff - 16'd1;
               end
            end
         end
         KIND_LOAD: begin
            if (!muted_ff) begin
               if (req_data.first_note) begin
                  playing_in  = 1'b0;
                  cur_freq_in = '0;
               end
               wr_note   = len_a < MAX_NOTES_CNT;
               wr_gap    = req_data.gap_after && !req_data.last_note
                           && (len_b < MAX_NOTES_CNT);
               length_in = len_b + NOTE_CNT_W'(wr_gap);
               if (req_data.last_note) begin
                  position_in = '0;
                  playing_in  = 1'b1;
                  if (len_a == '0) begin
                     cur_freq_in  = req_data.note_freq;
                     remaining_in = req_data.note_dur;
                  end else begin
                     cur_freq_in  = freq_store_ff[0];
                     remaining_in = dur_store_ff[0];
                  end
               end
            end
         end
         KIND_MUTE: begin
            if (req_data.mute_value != muted_ff) begin
               muted_in = req_data.mute_value;
               if (req_data.mute_value) begin
                  playing_in  = 1'b0;
                  length_in   = '0;
                  cur_freq_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
      result.tone_freq  = cur_freq_in;
      result.tone_on    = cur_freq_in != '0;
      result.is_playing = playing_in;
      result.is_muted   = muted_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_NOTES; i++) begin
         if (accept && wr_note && note_idx == NOTE_IDX_W'(i)) begin
            freq_store_ff[i] <= req_data.note_freq;
            dur_store_ff[i]  <= req_data.note_dur;
         end
         if (accept && wr_gap && gap_idx == NOTE_IDX_W'(i)) begin
            freq_store_ff[i] <= '0;
            dur_store_ff[i]  <= gap_ms_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         position_ff  <= '0;
         remaining_ff <= '0;
         playing_ff   <= 1'b0;
         muted_ff     <= 1'b0;
         cur_freq_ff  <= '0;
         gap_ms_ff    <= GAP_MS_RESET;
      end else begin
         if (accept) begin
            length_ff    <= length_in;
            position_ff  <= position_in;
            remaining_ff <= remaining_in;
            playing_ff   <= playing_in;
            muted_ff     <= muted_in;
            cur_freq_ff  <= cur_freq_in;
         end
         if (csr_valid && csr_ready) begin
            gap_ms_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_data_ff  <= result;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

FILE: rtl/tms_checker.sv
// Checker: port-level assertions for the tone melody sequencer, with its bind.
`timescale 1ns / 1ps
module tms_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tms_pkg::rsp_type rsp_data
);
   import tms_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.tone_on == (rsp_data.tone_freq != 16'd0))
      else $error("tone_on disagrees with tone_freq");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_muted |-> !rsp_data.is_playing && !rsp_data.tone_on)
      else $error("muted response shows play or tone");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_playing |-> rsp_data.tone_freq == 16'd0)
      else $error("tone driven while not playing");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("response or stall present after reset");

endmodule

bind tone_melody_sequencer tms_checker u_tms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
